### rtl/bshr_pkg.sv
// Shared constants for the beacon source hit ranker.
`default_nettype none

package bshr_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ENTRIES_DEF = 64;
   localparam int COUNT_BITS_DEF  = 32;

   // Fixed field widths of the request and response words
   localparam int MODE_W    = 2;
   localparam int ADDR_W    = 48;
   localparam int OUT_IDX_W = 6;
   localparam int OUT_CNT_W = 32;
   localparam int OUT_TOT_W = 7;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

endpackage

`default_nettype wire

### rtl/beacon_source_hit_ranker_top.sv
// Top level of the beacon source hit ranker: keyed hit table with ranked readout.
//
// Request channel (req_*): one word per command. Mode record looks up
// req_source_address in the table, bumps its count (saturating) or appends it
// with count 1, and returns one response word; a new address recorded into
// a full table returns one word flagged table_full and is dropped. Mode report
// returns one word per held entry, highest count first, equal counts in slot
// order, with last set on the final word; an empty table returns nothing.
// Mode clear empties the table and returns nothing; mode three is ignored.
// Response channel (rsp_*): one output register, held while rsp_stall is high.
// One command at a time; req_stall is high from acceptance of a record or a
// non-empty report until its last response word is loaded into the output
// register. A record scans the address memory one slot per cycle. A report
// ranks each entry by streaming the count memory past it, then reads the rank
// memory and the entry back for each response word. The table lives in
// single-port-read synchronous memories with registered read data.
// Response stalls only hold the sequencer in place.
// Reset: clears the entry count, the sequencer and the output valid; memory
// contents are not cleared and are never read before they are written.
`default_nettype none

module beacon_source_hit_ranker_top #(
   parameter int MAX_ENTRIES = bshr_pkg::MAX_ENTRIES_DEF,
   parameter int COUNT_BITS  = bshr_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bshr_pkg::MODE_W-1:0]      req_mode,
   input  logic [bshr_pkg::ADDR_W-1:0]      req_source_address,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bshr_pkg::OUT_IDX_W-1:0]   rsp_entry_index,
   output logic [bshr_pkg::OUT_CNT_W-1:0]   rsp_hit_count,
   output logic [bshr_pkg::ADDR_W-1:0]      rsp_entry_address,
   output logic                             rsp_was_new,
   output logic                             rsp_table_full,
   output logic [bshr_pkg::OUT_TOT_W-1:0]   rsp_entry_total,
   output logic                             rsp_last
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NUM_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [NUM_W-1:0]      NUM_MAX = NUM_W'(MAX_ENTRIES);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   // Sequencer states, one-hot
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,  // wait for a request word
      ST_R_SCAN = 10'b00_0000_0010,  // record: stream the address memory
      ST_R_OUT  = 10'b00_0000_0100,  // record: hand the result to the output register
      ST_K_HEAD = 10'b00_0000_1000,  // rank: read the count of the entry being placed
      ST_K_CAPT = 10'b00_0001_0000,  // rank: latch that count
      ST_K_SCAN = 10'b00_0010_0000,  // rank: count entries that sort ahead of it
      ST_K_WRIT = 10'b00_0100_0000,  // rank: store slot at its rank
      ST_E_RANK = 10'b00_1000_0000,  // emit: read slot at this rank
      ST_E_SLOT = 10'b01_0000_0000,  // emit: read that slot's entry
      ST_E_OUT  = 10'b10_0000_0000   // emit: load the response word
   } state_type;

   // Control registers
   state_type        state_ff, state_in;
   logic [NUM_W-1:0] n_ff, n_in;          // entries held
   logic             pend_ff, pend_in;    // a memory read is in flight
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [bshr_pkg::ADDR_W-1:0] key_ff, key_in;
   logic [NUM_W-1:0]            idx_ff, idx_in;      // next slot to read in a scan
   logic [NUM_W-1:0]            outer_ff, outer_in;  // entry being ranked / rank emitted
   logic [IDX_W-1:0]            rank_ff, rank_in;
   logic [IDX_W-1:0]            pidx_ff, pidx_in;    // slot of the read in flight
   logic [IDX_W-1:0]            slot_ff, slot_in;
   logic [COUNT_BITS-1:0]       ci_ff, ci_in;
   logic [IDX_W-1:0]            res_idx_ff, res_idx_in;
   logic [COUNT_BITS-1:0]       res_cnt_ff, res_cnt_in;
   logic                        res_new_ff, res_new_in;
   logic                        res_full_ff, res_full_in;

   // Output register payload
   logic [bshr_pkg::OUT_IDX_W-1:0] rsp_entry_index_ff, rsp_entry_index_in;
   logic [bshr_pkg::OUT_CNT_W-1:0] rsp_hit_count_ff, rsp_hit_count_in;
   logic [bshr_pkg::ADDR_W-1:0]    rsp_entry_address_ff, rsp_entry_address_in;
   logic                           rsp_was_new_ff, rsp_was_new_in;
   logic                           rsp_table_full_ff, rsp_table_full_in;
   logic [bshr_pkg::OUT_TOT_W-1:0] rsp_entry_total_ff, rsp_entry_total_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Memories and their registered read data
   logic [bshr_pkg::ADDR_W-1:0] addr_mem_ff [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]       cnt_mem_ff  [MAX_ENTRIES];
   logic [IDX_W-1:0]            rank_mem_ff [MAX_ENTRIES];
   logic [bshr_pkg::ADDR_W-1:0] addr_rd_ff;
   logic [COUNT_BITS-1:0]       cnt_rd_ff;
   logic [IDX_W-1:0]            rank_rd_ff;

   // Memory controls
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_idx;
   logic                  addr_we;
   logic                  cnt_we;
   logic [IDX_W-1:0]      wr_idx;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  rank_we;
   logic                  rank_rd_en;

   logic                  hit;
   logic                  ahead;
   logic                  out_free;
   logic                  emit_last;
   logic [COUNT_BITS-1:0] cnt_inc;

   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_index   = rsp_entry_index_ff;
   assign rsp_hit_count     = rsp_hit_count_ff;
   assign rsp_entry_address = rsp_entry_address_ff;
   assign rsp_was_new       = rsp_was_new_ff;
   assign rsp_table_full    = rsp_table_full_ff;
   assign rsp_entry_total   = rsp_entry_total_ff;
   assign rsp_last          = rsp_last_ff;

   // Output register can take a word this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Record: the read in flight matches the key
   assign hit     = pend_ff && (addr_rd_ff == key_ff);
   assign cnt_inc = (cnt_rd_ff == CNT_MAX) ? cnt_rd_ff : cnt_rd_ff + CNT_ONE;

   // Rank: streamed entry sorts ahead of the one being placed (stable, descending)
   assign ahead = (cnt_rd_ff > ci_ff) ||
                  ((cnt_rd_ff == ci_ff) && (pidx_ff < outer_ff[IDX_W-1:0]));

   assign emit_last = ((outer_ff + NUM_W'(1)) == n_ff);

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      pend_in     = pend_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      outer_in    = outer_ff;
      rank_in     = rank_ff;
      pidx_in     = pidx_ff;
      slot_in     = slot_ff;
      ci_in       = ci_ff;
      res_idx_in  = res_idx_ff;
      res_cnt_in  = res_cnt_ff;
      res_new_in  = res_new_ff;
      res_full_in = res_full_ff;

      // drop the word once taken
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_entry_index_in   = rsp_entry_index_ff;
      rsp_hit_count_in     = rsp_hit_count_ff;
      rsp_entry_address_in = rsp_entry_address_ff;
      rsp_was_new_in       = rsp_was_new_ff;
      rsp_table_full_in    = rsp_table_full_ff;
      rsp_entry_total_in   = rsp_entry_total_ff;
      rsp_last_in          = rsp_last_ff;

      rd_en      = 1'b0;
      rd_idx     = idx_ff[IDX_W-1:0];
      addr_we    = 1'b0;
      cnt_we     = 1'b0;
      wr_idx     = pidx_ff;
      cnt_wdata  = cnt_inc;
      rank_we    = 1'b0;
      rank_rd_en = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  bshr_pkg::MODE_RECORD: begin
                     key_in   = req_source_address;
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_R_SCAN;
                  end
                  bshr_pkg::MODE_REPORT: begin
                     if (n_ff != '0) begin
                        outer_in = '0;
                        state_in = ST_K_HEAD;
                     end
                  end
                  bshr_pkg::MODE_CLEAR: begin
                     n_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_R_SCAN: begin
            if (hit) begin
               // bump the matching count and write it back
               cnt_we      = 1'b1;
               wr_idx      = pidx_ff;
               cnt_wdata   = cnt_inc;
               res_idx_in  = pidx_ff;
               res_cnt_in  = cnt_inc;
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
               pend_in     = 1'b0;
               state_in    = ST_R_OUT;
            end else if (idx_ff < n_ff) begin
               rd_en   = 1'b1;
               rd_idx  = idx_ff[IDX_W-1:0];
               pend_in = 1'b1;
               pidx_in = idx_ff[IDX_W-1:0];
               idx_in  = idx_ff + NUM_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (n_ff == NUM_MAX) begin
               res_idx_in  = '0;
               res_cnt_in  = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
               state_in    = ST_R_OUT;
            end else begin
               // append at the next free slot
               addr_we     = 1'b1;
               cnt_we      = 1'b1;
               wr_idx      = n_ff[IDX_W-1:0];
               cnt_wdata   = CNT_ONE;
               res_idx_in  = n_ff[IDX_W-1:0];
               res_cnt_in  = CNT_ONE;
               res_new_in  = 1'b1;
               res_full_in = 1'b0;
               n_in        = n_ff + NUM_W'(1);
               state_in    = ST_R_OUT;
            end
         end

         ST_R_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_entry_index_in   = bshr_pkg::OUT_IDX_W'(res_idx_ff);
               rsp_hit_count_in     = bshr_pkg::OUT_CNT_W'(res_cnt_ff);
               rsp_entry_address_in = key_ff;
               rsp_was_new_in       = res_new_ff;
               rsp_table_full_in    = res_full_ff;
               rsp_entry_total_in   = bshr_pkg::OUT_TOT_W'(n_ff);
               rsp_last_in          = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         ST_K_HEAD: begin
            rd_en    = 1'b1;
            rd_idx   = outer_ff[IDX_W-1:0];
            state_in = ST_K_CAPT;
         end

         ST_K_CAPT: begin
            ci_in    = cnt_rd_ff;
            idx_in   = '0;
            rank_in  = '0;
            pend_in  = 1'b0;
            state_in = ST_K_SCAN;
         end

         ST_K_SCAN: begin
            if (pend_ff && ahead) begin
               rank_in = rank_ff + IDX_W'(1);
            end
            if (idx_ff < n_ff) begin
               rd_en   = 1'b1;
               rd_idx  = idx_ff[IDX_W-1:0];
               pend_in = 1'b1;
               pidx_in = idx_ff[IDX_W-1:0];
               idx_in  = idx_ff + NUM_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_K_WRIT;
               end
            end
         end

         ST_K_WRIT: begin
            rank_we = 1'b1;
            if (emit_last) begin
               outer_in = '0;
               state_in = ST_E_RANK;
            end else begin
               outer_in = outer_ff + NUM_W'(1);
               state_in = ST_K_HEAD;
            end
         end

         ST_E_RANK: begin
            rank_rd_en = 1'b1;
            state_in   = ST_E_SLOT;
         end

         ST_E_SLOT: begin
            rd_en    = 1'b1;
            rd_idx   = rank_rd_ff;
            slot_in  = rank_rd_ff;
            state_in = ST_E_OUT;
         end

         ST_E_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_entry_index_in   = bshr_pkg::OUT_IDX_W'(slot_ff);
               rsp_hit_count_in     = bshr_pkg::OUT_CNT_W'(cnt_rd_ff);
               rsp_entry_address_in = addr_rd_ff;
               rsp_was_new_in       = 1'b0;
               rsp_table_full_in    = 1'b0;
               rsp_entry_total_in   = bshr_pkg::OUT_TOT_W'(n_ff);
               rsp_last_in          = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  outer_in = outer_ff + NUM_W'(1);
                  state_in = ST_E_RANK;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      key_ff               <= key_in;
      idx_ff               <= idx_in;
      outer_ff             <= outer_in;
      rank_ff              <= rank_in;
      pidx_ff              <= pidx_in;
      slot_ff              <= slot_in;
      ci_ff                <= ci_in;
      res_idx_ff           <= res_idx_in;
      res_cnt_ff           <= res_cnt_in;
      res_new_ff           <= res_new_in;
      res_full_ff          <= res_full_in;
      rsp_entry_index_ff   <= rsp_entry_index_in;
      rsp_hit_count_ff     <= rsp_hit_count_in;
      rsp_entry_address_ff <= rsp_entry_address_in;
      rsp_was_new_ff       <= rsp_was_new_in;
      rsp_table_full_ff    <= rsp_table_full_in;
      rsp_entry_total_ff   <= rsp_entry_total_in;
      rsp_last_ff          <= rsp_last_in;
   end

   // Address memory
   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem_ff[wr_idx] <= key_ff;
      end
      if (rd_en) begin
         addr_rd_ff <= addr_mem_ff[rd_idx];
      end
   end

   // Count memory, read at the same slot as the address memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[wr_idx] <= cnt_wdata;
      end
      if (rd_en) begin
         cnt_rd_ff <= cnt_mem_ff[rd_idx];
      end
   end

   // Rank memory: slot held at each rank
   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem_ff[rank_ff] <= outer_ff[IDX_W-1:0];
      end
      if (rank_rd_en) begin
         rank_rd_ff <= rank_mem_ff[outer_ff[IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

### rtl/bshr_checker.sv
// Port-level checks for the beacon source hit ranker, bound to the top level.
`default_nettype none

module bshr_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [bshr_pkg::OUT_IDX_W-1:0] rsp_entry_index,
   input wire logic [bshr_pkg::OUT_CNT_W-1:0] rsp_hit_count,
   input wire logic [bshr_pkg::ADDR_W-1:0]    rsp_entry_address,
   input wire logic                           rsp_was_new,
   input wire logic                           rsp_table_full,
   input wire logic [bshr_pkg::OUT_TOT_W-1:0] rsp_entry_total,
   input wire logic                           rsp_last
);

   // No response word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_index) &&
         $stable(rsp_hit_count) && $stable(rsp_entry_address) &&
         $stable(rsp_was_new) && $stable(rsp_table_full) &&
         $stable(rsp_entry_total) && $stable(rsp_last))
      else $error("stalled response word changed");

   // A dropped record is a lone word with no slot and no count
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_was_new && rsp_last &&
         (rsp_entry_index == '0) && (rsp_hit_count == '0))
      else $error("malformed table-full word");

   // A new entry lands in the last slot with count one
   a_new_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_new |-> rsp_last && !rsp_table_full &&
         (rsp_hit_count == bshr_pkg::OUT_CNT_W'(1)) &&
         (rsp_entry_index ==
            bshr_pkg::OUT_IDX_W'(rsp_entry_total - bshr_pkg::OUT_TOT_W'(1))))
      else $error("malformed new-entry word");

endmodule

bind beacon_source_hit_ranker_top bshr_checker u_bshr_checker (.*);

`default_nettype wire

### bench/beacon_source_hit_ranker_top_tb.sv
// Self-checking testbench for the beacon source hit ranker: shadow table, ranked readout, stalls.
`timescale 1ns / 1ps

module beacon_source_hit_ranker_top_tb;

   // Build the block at its default sizes.
   localparam int SLOTS        = bshr_pkg::MAX_ENTRIES_DEF;
   localparam int CNT_BITS     = bshr_pkg::COUNT_BITS_DEF;
   localparam logic [bshr_pkg::OUT_CNT_W-1:0] CNT_MAX =
      bshr_pkg::OUT_CNT_W'((64'd1 << CNT_BITS) - 1);
   localparam logic [bshr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 220;
   localparam int POOL_SIZE    = 80;
   localparam int HOT_HITS     = 20;
   // A report of a full table ranks every entry before any word moves.
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 100;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [bshr_pkg::MODE_W-1:0]    req_mode;
   logic [bshr_pkg::ADDR_W-1:0]    req_source_address;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [bshr_pkg::OUT_IDX_W-1:0] rsp_entry_index;
   logic [bshr_pkg::OUT_CNT_W-1:0] rsp_hit_count;
   logic [bshr_pkg::ADDR_W-1:0]    rsp_entry_address;
   logic                           rsp_was_new;
   logic                           rsp_table_full;
   logic [bshr_pkg::OUT_TOT_W-1:0] rsp_entry_total;
   logic                           rsp_last;

   beacon_source_hit_ranker_top #(
      .MAX_ENTRIES(SLOTS),
      .COUNT_BITS (CNT_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_source_address(req_source_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_entry_address (rsp_entry_address),
      .rsp_was_new       (rsp_was_new),
      .rsp_table_full    (rsp_table_full),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_last          (rsp_last)
   );

   // One expected response word.
   typedef struct {
      logic [bshr_pkg::OUT_IDX_W-1:0] index;
      logic [bshr_pkg::OUT_CNT_W-1:0] hits;
      logic [bshr_pkg::ADDR_W-1:0]    address;
      logic                           was_new;
      logic                           table_full;
      logic [bshr_pkg::OUT_TOT_W-1:0] total;
      logic                           last;
   } hit_word_type;

   hit_word_type pending_hits[$];

   // Shadow copy of the hit table.
   logic [bshr_pkg::ADDR_W-1:0]    shadow_addr [SLOTS];
   logic [bshr_pkg::OUT_CNT_W-1:0] shadow_hits [SLOTS];
   int                             shadow_used = 0;

   int mismatches  = 0;
   int hold_cycles = 0;   // long receiver hold-off, counted down by the receiver process
   bit steady      = 1'b0; // no idling on either side while set

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(80, 25);
   endfunction

   function automatic logic [bshr_pkg::ADDR_W-1:0] rand_addr();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   function automatic void push_hit(input int idx,
                                    input logic [bshr_pkg::OUT_CNT_W-1:0] hits,
                                    input logic [bshr_pkg::ADDR_W-1:0] addr,
                                    input logic is_new, input logic full,
                                    input logic last);
      hit_word_type w;
      w.index      = bshr_pkg::OUT_IDX_W'(idx);
      w.hits       = hits;
      w.address    = addr;
      w.was_new    = is_new;
      w.table_full = full;
      w.total      = bshr_pkg::OUT_TOT_W'(shadow_used);
      w.last       = last;
      pending_hits.push_back(w);
   endfunction

   // Advance the shadow table by one accepted command and queue the words it must return.
   function automatic void tally_beacon(input logic [bshr_pkg::MODE_W-1:0] mode,
                                        input logic [bshr_pkg::ADDR_W-1:0] addr);
      int order [SLOTS];
      int i;
      int j;
      int v;
      int hit_slot;
      hit_slot = -1;
      case (mode)
         bshr_pkg::MODE_RECORD: begin
            for (i = 0; i < shadow_used; i++)
               if (hit_slot < 0 && shadow_addr[i] == addr) hit_slot = i;
            if (hit_slot >= 0) begin
               // Saturate at the all-ones value of the counter width.
               if (shadow_hits[hit_slot] < CNT_MAX) shadow_hits[hit_slot]++;
               push_hit(hit_slot, shadow_hits[hit_slot], addr, 1'b0, 1'b0, 1'b1);
            end else if (shadow_used >= SLOTS) begin
               // Drop the new address; the table stays as it is.
               push_hit(0, '0, addr, 1'b0, 1'b1, 1'b1);
            end else begin
               shadow_addr[shadow_used] = addr;
               shadow_hits[shadow_used] = 1;
               shadow_used++;
               push_hit(shadow_used - 1, 1, addr, 1'b1, 1'b0, 1'b1);
            end
         end
         bshr_pkg::MODE_REPORT: begin
            // Rank by count, highest first; equal counts keep slot order.
            for (i = 0; i < shadow_used; i++) order[i] = i;
            for (i = 1; i < shadow_used; i++) begin
               v = order[i];
               j = i;
               while (j > 0 && shadow_hits[order[j-1]] < shadow_hits[v]) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = v;
            end
            for (i = 0; i < shadow_used; i++)
               push_hit(order[i], shadow_hits[order[i]], shadow_addr[order[i]],
                        1'b0, 1'b0, i == shadow_used - 1);
         end
         bshr_pkg::MODE_CLEAR: shadow_used = 0;
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Predict on every accepted command word and check every accepted response word.
   // Both sides are sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin : score
      hit_word_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hits.size() == 0) begin
               flag_mismatch("response word with none pending", rsp_entry_address, '0);
            end else begin
               w = pending_hits.pop_front();
               if (rsp_entry_index !== w.index)
                  flag_mismatch("entry_index", rsp_entry_index, w.index);
               if (rsp_hit_count !== w.hits)
                  flag_mismatch("hit_count", rsp_hit_count, w.hits);
               if (rsp_entry_address !== w.address)
                  flag_mismatch("entry_address", rsp_entry_address, w.address);
               if (rsp_was_new !== w.was_new)
                  flag_mismatch("was_new", rsp_was_new, w.was_new);
               if (rsp_table_full !== w.table_full)
                  flag_mismatch("table_full", rsp_table_full, w.table_full);
               if (rsp_entry_total !== w.total)
                  flag_mismatch("entry_total", rsp_entry_total, w.total);
               if (rsp_last !== w.last)
                  flag_mismatch("last", rsp_last, w.last);
            end
         end
         if (req_valid && !req_stall) tally_beacon(req_mode, req_source_address);
      end
   end

   // Watchdog: end the run when no word moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stall runs, plus the long hold-off that a test requests.
   initial begin : receiver
      int run;
      run = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (run > 0) begin
            run--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            run = steady ? 0 : pick_gap();
         end
      end
   end

   // Offer one command word and hold it until accepted. Enter and leave at a falling edge;
   // valid stays high across back-to-back words and drops only for a gap.
   task automatic send_word(input logic [bshr_pkg::MODE_W-1:0] mode,
                            input logic [bshr_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_source_address <= addr;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // Report, clear and the unused mode on an empty table: none of them returns a word.
   task automatic test_empty_table();
      send_word(bshr_pkg::MODE_REPORT, rand_addr());
      send_word(bshr_pkg::MODE_CLEAR, rand_addr());
      send_word(MODE_UNUSED, rand_addr());
      send_word(bshr_pkg::MODE_REPORT, '0);
   endtask

   // Address extremes, repeat hits, ties in the ranking, ignored mode, clear and reuse.
   task automatic test_record_basics();
      send_word(bshr_pkg::MODE_RECORD, '0);
      send_word(bshr_pkg::MODE_RECORD, '1);
      send_word(bshr_pkg::MODE_RECORD, 48'hAAAA_AAAA_AAAA);
      send_word(bshr_pkg::MODE_RECORD, 48'h5555_5555_5555);
      send_word(bshr_pkg::MODE_RECORD, '1);
      send_word(bshr_pkg::MODE_RECORD, '0);
      send_word(bshr_pkg::MODE_RECORD, '1);
      send_word(MODE_UNUSED, 48'h5555_5555_5555);
      send_word(bshr_pkg::MODE_REPORT, '1);
      send_word(bshr_pkg::MODE_RECORD, 48'h5555_5555_5555);
      send_word(bshr_pkg::MODE_REPORT, '0);
      send_word(bshr_pkg::MODE_CLEAR, '1);
      send_word(bshr_pkg::MODE_REPORT, '0);
      // Stale slot contents must not leak: this lands back in slot zero as new.
      send_word(bshr_pkg::MODE_RECORD, 48'hAAAA_AAAA_AAAA);
      send_word(bshr_pkg::MODE_REPORT, '0);
   endtask

   // Hit one address many times next to a colder one and check the running count.
   task automatic test_repeat_hits();
      logic [bshr_pkg::ADDR_W-1:0] hot;
      hot = rand_addr();
      send_word(bshr_pkg::MODE_CLEAR, '0);
      send_word(bshr_pkg::MODE_RECORD, ~hot);
      repeat (HOT_HITS) send_word(bshr_pkg::MODE_RECORD, hot);
      send_word(bshr_pkg::MODE_REPORT, '0);
      send_word(bshr_pkg::MODE_RECORD, ~hot);
      send_word(bshr_pkg::MODE_RECORD, hot);
      send_word(bshr_pkg::MODE_REPORT, '0);
   endtask

   // Fill every slot, then hit the full-table drop both before and after a report.
   task automatic test_full_table();
      logic [bshr_pkg::ADDR_W-1:0] held [SLOTS];
      int i;
      send_word(bshr_pkg::MODE_CLEAR, '0);
      for (i = 0; i < SLOTS; i++) begin
         held[i]      = rand_addr();
         held[i][5:0] = 6'(i);
         send_word(bshr_pkg::MODE_RECORD, held[i]);
      end
      send_word(bshr_pkg::MODE_RECORD, rand_addr());
      send_word(bshr_pkg::MODE_RECORD, held[5]);
      send_word(bshr_pkg::MODE_RECORD, held[SLOTS-1]);
      send_word(bshr_pkg::MODE_RECORD, held[SLOTS-1]);
      send_word(bshr_pkg::MODE_REPORT, '0);
      send_word(bshr_pkg::MODE_RECORD, '1);
      send_word(bshr_pkg::MODE_RECORD, held[0]);
      send_word(bshr_pkg::MODE_REPORT, rand_addr());
      send_word(bshr_pkg::MODE_CLEAR, '0);
   endtask

   // Hold the receiver off for a long stretch while commands keep coming, so the
   // output register fills and the block has to stall its input.
   task automatic test_output_backpressure();
      logic [bshr_pkg::ADDR_W-1:0] a;
      int i;
      a = rand_addr();
      for (i = 0; i < 6; i++) send_word(bshr_pkg::MODE_RECORD, a + bshr_pkg::ADDR_W'(i));
      hold_cycles = 400;
      send_word(bshr_pkg::MODE_REPORT, '0);
      for (i = 0; i < 4; i++)
         send_word(bshr_pkg::MODE_RECORD, a + bshr_pkg::ADDR_W'(2 * i));
      send_word(bshr_pkg::MODE_REPORT, '0);
      send_word(bshr_pkg::MODE_CLEAR, '0);
   endtask

   // Random traffic: mostly records over a reused address pool with a hot subset, so
   // counts climb, ties form and the table grows; reports, clears and noise mixed in.
   task automatic test_random_traffic();
      logic [bshr_pkg::ADDR_W-1:0] pool [POOL_SIZE];
      logic [bshr_pkg::ADDR_W-1:0] addr;
      int sent;
      int r;
      int i;
      for (i = 0; i < POOL_SIZE; i++) pool[i] = rand_addr();
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         // Run a stretch with no idling on either side.
         steady = (sent >= 120 && sent < 170);
         r = $urandom_range(99);
         if (r < 3) begin
            send_word(MODE_UNUSED, rand_addr());
         end else begin
            if (r < 5) begin
               send_word(bshr_pkg::MODE_CLEAR, rand_addr());
            end else if (r < 13) begin
               send_word(bshr_pkg::MODE_REPORT, rand_addr());
            end else begin
               r = $urandom_range(99);
               if (r < 40) addr = pool[$urandom_range(7)];
               else if (r < 85) addr = pool[$urandom_range(POOL_SIZE - 1)];
               else addr = rand_addr();
               send_word(bshr_pkg::MODE_RECORD, addr);
            end
            sent++;
         end
      end
      steady = 1'b0;
      send_word(bshr_pkg::MODE_REPORT, '0);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_mode           = bshr_pkg::MODE_RECORD;
      req_source_address = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_record_basics();
      test_repeat_hits();
      test_full_table();
      test_output_backpressure();
      test_random_traffic();

      // Drain: drop valid, wait out every pending word, then let the block settle.
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### beacon_source_hit_ranker_top.f
rtl/bshr_pkg.sv
rtl/beacon_source_hit_ranker_top.sv
rtl/bshr_checker.sv
bench/beacon_source_hit_ranker_top_tb.sv
